@@ hw/rtl/efc_pkg.sv @@
package efc_pkg;

	localparam int OFFSET_BITS = 11;
	localparam int COUNT_BITS  = 32;
	localparam int NUM_CTR     = 5;
	localparam int CTR_IDX_W   = $clog2(NUM_CTR);

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [CTR_IDX_W-1:0]   ctr_idx_t;

	localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

	// frame_kind codes
	localparam logic [2:0] KIND_IPV4  = 3'd0;
	localparam logic [2:0] KIND_ARP   = 3'd1;
	localparam logic [2:0] KIND_OTHER = 3'd2;
	localparam logic [2:0] KIND_RAW   = 3'd3;
	localparam logic [2:0] KIND_SNAP  = 3'd4;
	localparam logic [2:0] KIND_LLC   = 3'd5;
	localparam logic [2:0] KIND_RUNT  = 3'd6;

	// counter slots
	localparam ctr_idx_t CTR_IPV4 = CTR_IDX_W'(0);
	localparam ctr_idx_t CTR_ARP  = CTR_IDX_W'(1);
	localparam ctr_idx_t CTR_RAW  = CTR_IDX_W'(2);
	localparam ctr_idx_t CTR_SNAP = CTR_IDX_W'(3);
	localparam ctr_idx_t CTR_LLC  = CTR_IDX_W'(4);

	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [15:0] ETYPE_ARP    = 16'h0806;
	localparam logic [15:0] SAPS_RAW     = 16'hFFFF;
	localparam logic [15:0] SAPS_SNAP    = 16'hAAAA;
	localparam logic [15:0] SAPS_IP      = 16'h0606;
	localparam logic [15:0] SAPS_STP     = 16'h4242;
	localparam logic [15:0] THRESH_RESET = 16'd1500;

	// byte offsets within the frame
	localparam offset_t OFF_TL_HI   = OFFSET_BITS'(12);
	localparam offset_t OFF_TL_LO   = OFFSET_BITS'(13);
	localparam offset_t OFF_SAP_HI  = OFFSET_BITS'(14);
	localparam offset_t OFF_SAP_LO  = OFFSET_BITS'(15);
	localparam offset_t OFF_SNAP_HI = OFFSET_BITS'(20);
	localparam offset_t OFF_SNAP_LO = OFFSET_BITS'(21);
	localparam offset_t OFF_MIN_LEN = OFFSET_BITS'(13);

	localparam offset_t IP_BASE_ETH2 = OFFSET_BITS'(14);
	localparam offset_t IP_BASE_LLC  = OFFSET_BITS'(17);
	localparam offset_t IP_BASE_SNAP = OFFSET_BITS'(22);
	localparam offset_t IP_BASE_NONE = OFFSET_BITS'(0);

	// byte positions inside the IPv4 header
	localparam offset_t IP_REL_VER    = OFFSET_BITS'(0);
	localparam offset_t IP_REL_LEN_HI = OFFSET_BITS'(2);
	localparam offset_t IP_REL_LEN_LO = OFFSET_BITS'(3);
	localparam offset_t IP_REL_TTL    = OFFSET_BITS'(8);
	localparam offset_t IP_REL_PROTO  = OFFSET_BITS'(9);
	localparam offset_t IP_REL_SRC    = OFFSET_BITS'(12);
	localparam offset_t IP_REL_SRC_E  = OFFSET_BITS'(15);
	localparam offset_t IP_REL_DST    = OFFSET_BITS'(16);
	localparam offset_t IP_REL_DST_E  = OFFSET_BITS'(19);

	typedef struct packed {
		logic [2:0]  frame_kind;
		logic [15:0] type_or_length;
		logic [15:0] llc_saps;
		logic [3:0]  ip_version;
		logic [3:0]  ip_header_words;
		logic [7:0]  ip_protocol;
		logic [7:0]  ip_ttl;
		logic [15:0] ip_total_length;
		logic [31:0] ip_source;
		logic [31:0] ip_destination;
		logic [15:0] payload_code;
	} result_t;

	typedef struct packed {
		logic     has_ctr;
		ctr_idx_t ctr_idx;
	} ctr_sel_t;

endpackage

@@ hw/rtl/efc_in_if.sv @@
interface efc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

@@ hw/rtl/efc_out_if.sv @@
interface efc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_kind;
	logic [15:0] type_or_length;
	logic [15:0] llc_saps;
	logic [3:0]  ip_version;
	logic [3:0]  ip_header_words;
	logic [7:0]  ip_protocol;
	logic [7:0]  ip_ttl;
	logic [15:0] ip_total_length;
	logic [31:0] ip_source;
	logic [31:0] ip_destination;
	logic [15:0] payload_code;
	logic [31:0] kind_count;

	modport source (
		output valid, input ready,
		output frame_kind, output type_or_length, output llc_saps,
		output ip_version, output ip_header_words, output ip_protocol, output ip_ttl,
		output ip_total_length, output ip_source, output ip_destination,
		output payload_code, output kind_count
	);
	modport sink (
		input valid, output ready,
		input frame_kind, input type_or_length, input llc_saps,
		input ip_version, input ip_header_words, input ip_protocol, input ip_ttl,
		input ip_total_length, input ip_source, input ip_destination,
		input payload_code, input kind_count
	);
endinterface

@@ hw/rtl/efc_capture.sv @@
module efc_capture (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              frame_end,
	input  logic [15:0]       threshold,
	output efc_pkg::result_t  result,
	output efc_pkg::ctr_sel_t ctr_sel
);

	efc_pkg::offset_t offset_q;
	logic [15:0] tl_q, saps_q, snap_q, code_q;
	logic [31:0] src_q, dst_q;
	logic [39:0] meta_q;

	logic [15:0] tl_n, saps_n, snap_n, code_n;
	logic [31:0] src_n, dst_n;
	logic [39:0] meta_n;
	logic        eth2;
	efc_pkg::offset_t ip_base, rel;

	always_comb begin
		tl_n   = tl_q;
		saps_n = saps_q;
		snap_n = snap_q;
		code_n = code_q;
		src_n  = src_q;
		dst_n  = dst_q;
		meta_n = meta_q;

		if (offset_q == efc_pkg::OFF_TL_HI)   tl_n[15:8]   = data_byte;
		if (offset_q == efc_pkg::OFF_TL_LO)   tl_n[7:0]    = data_byte;
		if (offset_q == efc_pkg::OFF_SAP_HI)  saps_n[15:8] = data_byte;
		if (offset_q == efc_pkg::OFF_SAP_LO)  saps_n[7:0]  = data_byte;
		if (offset_q == efc_pkg::OFF_SNAP_HI) snap_n[15:8] = data_byte;
		if (offset_q == efc_pkg::OFF_SNAP_LO) snap_n[7:0]  = data_byte;

		eth2 = tl_n > threshold;

		if (eth2 && tl_n == efc_pkg::ETYPE_ARP) begin
			if (offset_q == efc_pkg::OFF_SNAP_HI) code_n[15:8] = data_byte;
			if (offset_q == efc_pkg::OFF_SNAP_LO) code_n[7:0]  = data_byte;
		end else if (!eth2 && saps_n == efc_pkg::SAPS_STP
				&& offset_q == efc_pkg::OFF_SNAP_HI) begin
			code_n = {8'h00, data_byte};
		end

		if (eth2)
			ip_base = (tl_n == efc_pkg::ETYPE_IPV4) ? efc_pkg::IP_BASE_ETH2
				: efc_pkg::IP_BASE_NONE;
		else if (saps_n == efc_pkg::SAPS_SNAP)
			ip_base = (snap_n == efc_pkg::ETYPE_IPV4) ? efc_pkg::IP_BASE_SNAP
				: efc_pkg::IP_BASE_NONE;
		else if (saps_n == efc_pkg::SAPS_IP)
			ip_base = efc_pkg::IP_BASE_LLC;
		else
			ip_base = efc_pkg::IP_BASE_NONE;

		rel = offset_q - ip_base;
		if (ip_base != efc_pkg::IP_BASE_NONE && offset_q >= ip_base) begin
			case (rel) inside
				efc_pkg::IP_REL_VER:    meta_n[39:32] = data_byte;
				efc_pkg::IP_REL_LEN_HI: meta_n[15:8]  = data_byte;
				efc_pkg::IP_REL_LEN_LO: meta_n[7:0]   = data_byte;
				efc_pkg::IP_REL_TTL:    meta_n[23:16] = data_byte;
				efc_pkg::IP_REL_PROTO:  meta_n[31:24] = data_byte;
				[efc_pkg::IP_REL_SRC:efc_pkg::IP_REL_SRC_E]: src_n = {src_q[23:0], data_byte};
				[efc_pkg::IP_REL_DST:efc_pkg::IP_REL_DST_E]: dst_n = {dst_q[23:0], data_byte};
				default: ;
			endcase
		end
	end

	// classify from the captures as they stand after this byte
	always_comb begin
		result                = '0;
		ctr_sel               = '0;
		result.type_or_length = tl_n;
		if (offset_q < efc_pkg::OFF_MIN_LEN) begin
			result.frame_kind = efc_pkg::KIND_RUNT;
		end else begin
			if (eth2) begin
				if (tl_n == efc_pkg::ETYPE_IPV4) begin
					result.frame_kind = efc_pkg::KIND_IPV4;
					ctr_sel           = '{has_ctr: 1'b1, ctr_idx: efc_pkg::CTR_IPV4};
				end else if (tl_n == efc_pkg::ETYPE_ARP) begin
					result.frame_kind   = efc_pkg::KIND_ARP;
					result.payload_code = code_n;
					ctr_sel             = '{has_ctr: 1'b1, ctr_idx: efc_pkg::CTR_ARP};
				end else begin
					result.frame_kind = efc_pkg::KIND_OTHER;
				end
			end else if (saps_n == efc_pkg::SAPS_RAW) begin
				result.frame_kind = efc_pkg::KIND_RAW;
				ctr_sel           = '{has_ctr: 1'b1, ctr_idx: efc_pkg::CTR_RAW};
			end else if (saps_n == efc_pkg::SAPS_SNAP) begin
				result.frame_kind = efc_pkg::KIND_SNAP;
				result.llc_saps   = saps_n;
				ctr_sel           = '{has_ctr: 1'b1, ctr_idx: efc_pkg::CTR_SNAP};
			end else begin
				result.frame_kind = efc_pkg::KIND_LLC;
				result.llc_saps   = saps_n;
				if (saps_n == efc_pkg::SAPS_STP)
					result.payload_code = code_n;
				ctr_sel           = '{has_ctr: 1'b1, ctr_idx: efc_pkg::CTR_LLC};
			end
			if (ip_base != efc_pkg::IP_BASE_NONE) begin
				result.ip_version      = meta_n[39:36];
				result.ip_header_words = meta_n[35:32];
				result.ip_protocol     = meta_n[31:24];
				result.ip_ttl          = meta_n[23:16];
				result.ip_total_length = meta_n[15:0];
				result.ip_source       = src_n;
				result.ip_destination  = dst_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			tl_q     <= '0;
			saps_q   <= '0;
			snap_q   <= '0;
			code_q   <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			meta_q   <= '0;
		end else if (take) begin
			if (frame_end) begin
				// clear captures for the next frame
				offset_q <= '0;
				tl_q     <= '0;
				saps_q   <= '0;
				snap_q   <= '0;
				code_q   <= '0;
				src_q    <= '0;
				dst_q    <= '0;
				meta_q   <= '0;
			end else begin
				if (offset_q != efc_pkg::OFFSET_MAX)
					offset_q <= offset_q + 1'b1;
				tl_q   <= tl_n;
				saps_q <= saps_n;
				snap_q <= snap_n;
				code_q <= code_n;
				src_q  <= src_n;
				dst_q  <= dst_n;
				meta_q <= meta_n;
			end
		end
	end

endmodule

@@ hw/rtl/ethernet_frame_classifier_core.sv @@
// Channel    Dir  Handshake      Carries
// frame_in   in   valid/ready    data_byte, frame_end (one frame byte per item)
// result_out out  valid/ready    frame kind, captured header fields, kind_count
// cfg        in   cfg_we         cfg_wdata -> length_threshold
//
// One byte per clock while ready; a result is valid in the cycle after the last byte.
// Each byte is captured and classified in the cycle it is accepted; one output register.
// frame_in is ready whenever the output register is empty or being drained.
// Reset clears the offset, all captures, the kind counters and sets the threshold to 1500.
module ethernet_frame_classifier_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	efc_in_if.sink            frame_in,
	efc_out_if.source         result_out
);

	logic [15:0]       threshold_q;
	logic              take;
	efc_pkg::result_t  result;
	efc_pkg::ctr_sel_t ctr_sel;
	efc_pkg::count_t   counters_q [efc_pkg::NUM_CTR];
	efc_pkg::count_t   cnt_cur, cnt_next;

	logic              out_valid_q;
	efc_pkg::result_t  out_q;
	efc_pkg::count_t   out_cnt_q;

	assign frame_in.ready = !out_valid_q || result_out.ready;
	assign take           = frame_in.valid && frame_in.ready;

	efc_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (frame_in.data_byte),
		.frame_end (frame_in.frame_end),
		.threshold (threshold_q),
		.result    (result),
		.ctr_sel   (ctr_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= efc_pkg::THRESH_RESET;
		else if (cfg_we)
			threshold_q <= cfg_wdata;
	end

	// saturating increment of the selected counter
	always_comb begin
		cnt_cur  = counters_q[ctr_sel.ctr_idx];
		cnt_next = (&cnt_cur) ? cnt_cur : cnt_cur + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < efc_pkg::NUM_CTR; i++)
				counters_q[i] <= '0;
		end else if (take && frame_in.frame_end && ctr_sel.has_ctr) begin
			counters_q[ctr_sel.ctr_idx] <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= frame_in.frame_end;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take && frame_in.frame_end) begin
			out_q     <= result;
			out_cnt_q <= ctr_sel.has_ctr ? cnt_next : '0;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.frame_kind      = out_q.frame_kind;
	assign result_out.type_or_length  = out_q.type_or_length;
	assign result_out.llc_saps        = out_q.llc_saps;
	assign result_out.ip_version      = out_q.ip_version;
	assign result_out.ip_header_words = out_q.ip_header_words;
	assign result_out.ip_protocol     = out_q.ip_protocol;
	assign result_out.ip_ttl          = out_q.ip_ttl;
	assign result_out.ip_total_length = out_q.ip_total_length;
	assign result_out.ip_source       = out_q.ip_source;
	assign result_out.ip_destination  = out_q.ip_destination;
	assign result_out.payload_code    = out_q.payload_code;
	assign result_out.kind_count      = out_cnt_q;

endmodule
